FILE: rtl/psd_pkg.sv
// Shared types and constants for the PackBits segment decoder.
// No dependencies; packbits_segment_decoder and psd_res_fifo refer to this package by scope.
`default_nettype none

package psd_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_NUM_SEGMENTS      = 2'd0;
	localparam logic [1:0] CFG_SAMPLES_PER_PIXEL = 2'd1;
	localparam logic [1:0] CFG_PLANAR_MODE       = 2'd2;
	localparam logic [1:0] CFG_SEGMENT_BYTES     = 2'd3;

	localparam int CFG_DATA_W = 17;
	localparam int ADDR_W     = 20;
	localparam int COUNT_W    = 17;

	// Result queue
	localparam int RES_FIFO_DEPTH = 4;
	localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
	localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

	// PackBits parser state
	typedef enum logic [1:0] {
		PM_HEADER    = 2'd0,
		PM_LITERAL   = 2'd1,
		PM_REPLICATE = 2'd2
	} parse_mode_t;

	// One decoded run
	typedef struct packed {
		logic [7:0]         value;
		logic [COUNT_W-1:0] count;
		logic [ADDR_W-1:0]  dest_address;
		logic [3:0]         stride;
		logic               segment_last;
		logic               missing_data;
	} res_t;

	// 4-bit divide table: entry {dividend, divisor} holds {quotient, remainder}.
	// Divisor zero entries are unused and read as zero.
	typedef logic [255:0][7:0] div_tab_t;

	function automatic div_tab_t build_div_tab();
		div_tab_t   t;
		logic [3:0] q;
		logic [3:0] r;
		t = '0;
		for (int b = 1; b < 16; b++) begin
			q = 4'd0;
			r = 4'd0;
			for (int i = 0; i < 16; i++) begin
				t[8'(i * 16 + b)] = {q, r};
				if (r == 4'(b - 1)) begin
					r = 4'd0;
					q = q + 4'd1;
				end else begin
					r = r + 4'd1;
				end
			end
		end
		return t;
	endfunction

	localparam div_tab_t DIV_TAB = build_div_tab();

endpackage

`default_nettype wire

FILE: rtl/psd_if.sv
// Stream interfaces of the PackBits segment decoder: compressed bytes in,
// decoded runs out. Depends on nothing.
`default_nettype none

interface psd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       segment_start;
	logic       data_end;

	modport source(output valid, data_byte, segment_start, data_end, input ready);
	modport sink(input valid, data_byte, segment_start, data_end, output ready);
endinterface

interface psd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  value;
	logic [16:0] count;
	logic [19:0] dest_address;
	logic [3:0]  stride;
	logic        segment_last;
	logic        missing_data;

	modport source(output valid, value, count, dest_address, stride, segment_last,
		missing_data, input ready);
	modport sink(input valid, value, count, dest_address, stride, segment_last,
		missing_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/packbits_segment_decoder.sv
// PackBits segment decoder. A byte is held in the input register; its runs are written
// into the result queue and offered on the output port from there.
// Throughput: one byte per cycle while the queue has room; the output moves one run per
// cycle while ready is high, so a byte that yields two runs needs two output transfers.
// The 4-entry result queue sets the input back-pressure: a byte waits while more
// than two runs are queued.
// Reset (arst_n low, async): config to defaults, no segment open, queue empty.
// Depends on psd_pkg, psd_if and psd_res_fifo.
`default_nettype none

module packbits_segment_decoder #(
	parameter int MAX_SEGMENT_BYTES = 65536,
	parameter int MAX_SEGMENTS      = 15
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [psd_pkg::CFG_DATA_W-1:0]  cfg_data,
	psd_in_if.sink                               byte_stream,
	psd_out_if.source                            run_stream
);

	localparam int SEGB_CAP = (MAX_SEGMENT_BYTES < 131071) ? MAX_SEGMENT_BYTES : 131071;
	localparam int BL_W     = $clog2(SEGB_CAP + 1);
	localparam int SI_W     = $clog2(MAX_SEGMENTS + 1);
	localparam int SEGB_RST = (65536 < SEGB_CAP) ? 65536 : SEGB_CAP;
	localparam int AW       = psd_pkg::ADDR_W;
	localparam int CW       = psd_pkg::COUNT_W;

	// Configuration registers
	logic [3:0]  num_segments_q;
	logic [3:0]  samples_per_pixel_q;
	logic        planar_mode_q;
	logic [16:0] segment_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_segments_q      <= 4'd1;
			samples_per_pixel_q <= 4'd1;
			planar_mode_q       <= 1'b0;
			segment_bytes_q     <= 17'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				psd_pkg::CFG_NUM_SEGMENTS:      num_segments_q      <= cfg_data[3:0];
				psd_pkg::CFG_SAMPLES_PER_PIXEL: samples_per_pixel_q <= cfg_data[3:0];
				psd_pkg::CFG_PLANAR_MODE:       planar_mode_q       <= cfg_data[0];
				psd_pkg::CFG_SEGMENT_BYTES:     segment_bytes_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective layout values, registered from the configuration registers
	logic [3:0]      eff_nseg;
	logic [3:0]      eff_spp;
	logic [7:0]      nseg_div;
	logic [3:0]      eff_bps;
	logic [BL_W-1:0] eff_segb;

	logic [3:0]      nseg_q;
	logic [3:0]      bps_q;
	logic [3:0]      stride_q;
	logic [BL_W-1:0] segb_q;
	logic [AW-1:0]   seg_inc_q;

	always_comb begin
		eff_nseg = (num_segments_q == 4'd0) ? 4'd1 : num_segments_q;
		if (int'(eff_nseg) > MAX_SEGMENTS) begin
			eff_nseg = 4'(MAX_SEGMENTS);
		end
		eff_spp  = (samples_per_pixel_q == 4'd0) ? 4'd1 : samples_per_pixel_q;
		nseg_div = psd_pkg::DIV_TAB[{eff_nseg, eff_spp}];
		// a sample count that does not divide the segments gives one byte per sample
		eff_bps  = (nseg_div[3:0] != 4'd0) ? 4'd1 : nseg_div[7:4];
		if (segment_bytes_q == 17'd0) begin
			eff_segb = BL_W'(1);
		end else if (int'(segment_bytes_q) > SEGB_CAP) begin
			eff_segb = BL_W'(SEGB_CAP);
		end else begin
			eff_segb = BL_W'(segment_bytes_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nseg_q    <= 4'd1;
			bps_q     <= 4'd1;
			stride_q  <= 4'd1;
			segb_q    <= BL_W'(SEGB_RST);
			seg_inc_q <= AW'(1);
		end else begin
			nseg_q    <= eff_nseg;
			bps_q     <= eff_bps;
			stride_q  <= planar_mode_q ? eff_bps : eff_nseg;
			segb_q    <= eff_segb;
			seg_inc_q <= planar_mode_q ? AW'(eff_bps) * AW'(eff_segb) : AW'(eff_bps);
		end
	end

	// Input register
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       end_s1;
	logic       room2;
	logic       go_s1;

	assign go_s1             = v_s1 && room2;
	assign byte_stream.ready = !v_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			v_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			byte_s1  <= byte_stream.data_byte;
			start_s1 <= byte_stream.segment_start;
			end_s1   <= byte_stream.data_end;
		end
	end

	// Decoder state
	logic [SI_W-1:0]      seg_idx_q;
	logic [AW-1:0]        wa_q;
	logic [BL_W-1:0]      bl_q;
	psd_pkg::parse_mode_t pm_q;
	logic [7:0]           rl_q;
	logic [7:0]           rc_q;
	logic                 miss_q;

	// Start address of the segment about to open
	logic [7:0]    seg_div;
	logic [AW-1:0] open_wa;

	assign seg_div = psd_pkg::DIV_TAB[{4'(seg_idx_q), bps_q}];
	assign open_wa = AW'(seg_div[7:4] * seg_inc_q) + AW'(bps_q - 4'd1 - seg_div[3:0]);

	// One byte: close on start, open, parse or emit, close on end
	logic [SI_W-1:0]      n_seg_idx;
	logic [AW-1:0]        n_wa;
	logic [BL_W-1:0]      n_bl;
	psd_pkg::parse_mode_t n_pm;
	logic [7:0]           n_rl;
	logic [7:0]           n_rc;
	logic                 n_miss;
	logic [CW-1:0]        rep_cnt;
	psd_pkg::res_t        res_a;
	psd_pkg::res_t        res_b;
	psd_pkg::res_t        res_c;
	logic                 va;
	logic                 vb;
	logic                 vc;

	always_comb begin
		n_seg_idx = seg_idx_q;
		n_wa      = wa_q;
		n_bl      = bl_q;
		n_pm      = pm_q;
		n_rl      = rl_q;
		n_rc      = rc_q;
		n_miss    = miss_q;
		rep_cnt   = (CW'(rc_q) > CW'(bl_q)) ? CW'(bl_q) : CW'(rc_q);
		if (rep_cnt == '0) begin
			rep_cnt = CW'(1);
		end
		res_a = '0;
		res_b = '0;
		res_c = '0;
		va    = 1'b0;
		vb    = 1'b0;
		vc    = 1'b0;

		if (start_s1) begin
			// previous segment still open: zero fill the rest
			if (bl_q != '0) begin
				n_miss             = 1'b1;
				va                 = 1'b1;
				res_a.count        = CW'(bl_q);
				res_a.dest_address = wa_q;
				res_a.stride       = stride_q;
				res_a.segment_last = 1'b1;
				res_a.missing_data = 1'b1;
			end
			n_pm = psd_pkg::PM_HEADER;
			n_rl = 8'd0;
			n_rc = 8'd0;
			n_bl = '0;
			if (4'(seg_idx_q) < nseg_q) begin
				n_wa      = open_wa;
				n_bl      = segb_q;
				n_seg_idx = seg_idx_q + SI_W'(1);
			end
		end

		if (n_bl != '0) begin
			case (n_pm)
				psd_pkg::PM_LITERAL: begin
					vb                 = 1'b1;
					res_b.value        = byte_s1;
					res_b.count        = CW'(1);
					res_b.dest_address = n_wa;
					res_b.stride       = stride_q;
					res_b.segment_last = n_bl == BL_W'(1);
					res_b.missing_data = n_miss;
					n_wa               = n_wa + AW'(stride_q);
					n_bl               = n_bl - BL_W'(1);
					if (n_rl != 8'd0) begin
						n_rl = n_rl - 8'd1;
					end
					if (n_rl == 8'd0) begin
						n_pm = psd_pkg::PM_HEADER;
					end
				end
				psd_pkg::PM_REPLICATE: begin
					vb                 = 1'b1;
					res_b.value        = byte_s1;
					res_b.count        = rep_cnt;
					res_b.dest_address = n_wa;
					res_b.stride       = stride_q;
					res_b.segment_last = n_bl == BL_W'(rep_cnt);
					res_b.missing_data = n_miss;
					n_wa               = n_wa + AW'(rep_cnt[7:0]) * AW'(stride_q);
					n_bl               = n_bl - BL_W'(rep_cnt);
					n_pm               = psd_pkg::PM_HEADER;
				end
				psd_pkg::PM_HEADER: begin
					if (byte_s1 < 8'd128) begin
						n_rl = byte_s1 + 8'd1;
						n_pm = psd_pkg::PM_LITERAL;
					end else if (byte_s1 > 8'd128) begin
						n_rc = 8'(9'd257 - {1'b0, byte_s1});
						n_pm = psd_pkg::PM_REPLICATE;
					end else begin
						n_pm = psd_pkg::PM_HEADER;
					end
				end
				default: n_pm = psd_pkg::PM_HEADER;
			endcase
		end

		if (end_s1) begin
			// data ran out: zero fill what is left
			if (n_bl != '0) begin
				n_miss             = 1'b1;
				vc                 = 1'b1;
				res_c.count        = CW'(n_bl);
				res_c.dest_address = n_wa;
				res_c.stride       = stride_q;
				res_c.segment_last = 1'b1;
				res_c.missing_data = 1'b1;
				n_bl               = '0;
			end
			n_pm = psd_pkg::PM_HEADER;
			n_rl = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_idx_q <= '0;
			wa_q      <= '0;
			bl_q      <= '0;
			pm_q      <= psd_pkg::PM_HEADER;
			rl_q      <= 8'd0;
			rc_q      <= 8'd0;
			miss_q    <= 1'b0;
		end else if (go_s1) begin
			seg_idx_q <= n_seg_idx;
			wa_q      <= n_wa;
			bl_q      <= n_bl;
			pm_q      <= n_pm;
			rl_q      <= n_rl;
			rc_q      <= n_rc;
			miss_q    <= n_miss;
		end
	end

	// Pack the runs of this byte into queue slots, in order
	psd_pkg::res_t [1:0] wdata;
	logic [1:0]          push_num;

	always_comb begin
		wdata[0] = va ? res_a : (vb ? res_b : res_c);
		wdata[1] = (va && vb) ? res_b : res_c;
		push_num = go_s1 ? (2'(va) + 2'(vb) + 2'(vc)) : 2'd0;
	end

	psd_res_fifo u_res_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_num   (push_num),
		.wdata      (wdata),
		.room2      (room2),
		.run_stream (run_stream)
	);

endmodule

`default_nettype wire

FILE: rtl/psd_res_fifo.sv
// Result queue: takes up to two runs per cycle, hands out one per transfer.
// Depends on psd_pkg and psd_out_if.
`default_nettype none

module psd_res_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [1:0]            push_num,
	input  wire psd_pkg::res_t [1:0]   wdata,
	output logic                       room2,
	psd_out_if.source                  run_stream
);

	psd_pkg::res_t mem_q [psd_pkg::RES_FIFO_DEPTH];

	logic [psd_pkg::RES_PTR_W-1:0] wr_ptr_q;
	logic [psd_pkg::RES_PTR_W-1:0] rd_ptr_q;
	logic [psd_pkg::RES_CNT_W-1:0] cnt_q;
	logic                          pop;
	psd_pkg::res_t                 head;

	assign pop   = run_stream.valid && run_stream.ready;
	assign room2 = cnt_q <= psd_pkg::RES_CNT_W'(psd_pkg::RES_FIFO_DEPTH - 2);

	// Storage: slot 0 at the write pointer, slot 1 right behind it
	always_ff @(posedge clk) begin
		if (push_num != 2'd0) begin
			mem_q[wr_ptr_q] <= wdata[0];
		end
		if (push_num == 2'd2) begin
			mem_q[wr_ptr_q + psd_pkg::RES_PTR_W'(1)] <= wdata[1];
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + psd_pkg::RES_PTR_W'(push_num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + psd_pkg::RES_PTR_W'(1);
			end
			cnt_q <= cnt_q + psd_pkg::RES_CNT_W'(push_num) - psd_pkg::RES_CNT_W'(pop);
		end
	end

	// Head of queue drives the output channel
	assign head                    = mem_q[rd_ptr_q];
	assign run_stream.valid        = cnt_q != '0;
	assign run_stream.value        = head.value;
	assign run_stream.count        = head.count;
	assign run_stream.dest_address = head.dest_address;
	assign run_stream.stride       = head.stride;
	assign run_stream.segment_last = head.segment_last;
	assign run_stream.missing_data = head.missing_data;

endmodule

`default_nettype wire
